// File: design/wcps_pkg.sv
package wcps_pkg;

   localparam int WheelsDefault = 4;
   localparam int SlotsDefault  = 5;

   localparam int AngleWidth = 16;
   localparam int PowerWidth = 24;
   localparam int LimitWidth = 16;
   localparam int CountWidth = 17;
   localparam int MsWidth    = 32;

   localparam logic [PowerWidth-1:0] PowerLimitReset   = 24'd20480;
   localparam logic [LimitWidth-1:0] FrameLimitReset   = 16'd10;
   localparam logic [PowerWidth-1:0] StartupBudgetReset = 24'd0;

   localparam logic [1:0] RegPowerLimit    = 2'd0;
   localparam logic [1:0] RegFrameLimit    = 2'd1;
   localparam logic [1:0] RegStartupBudget = 2'd2;

   typedef enum logic [1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_READY   = 2'd1,
      FUNC_COMPUTE = 2'd2,
      FUNC_TICK    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT,
      ST_SUM,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_DIV_STORE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mark_ready;
      logic capture_tick;
      logic slot_step;
      logic sum_clear;
      logic sum_add;
      logic index_clear;
      logic div_load;
      logic div_step;
      logic budget_store;
      logic frame_emit;
   } ctrl_type;

   typedef struct packed {
      logic slot_done;
      logic sum_done;
      logic div_done;
      logic last_wheel;
   } status_type;

endpackage

// File: design/wcps_datapath.sv
module wcps_datapath
   import wcps_pkg::*;
#(
   parameter int WHEELS = WheelsDefault,
   parameter int SLOTS  = SlotsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ctrl_type                       ctrl,
   output status_type                     status,
   input  logic [1:0]                     req_wheel,
   input  logic signed [AngleWidth-1:0]   req_target_angle,
   input  logic signed [AngleWidth-1:0]   req_target_speed,
   input  logic [PowerWidth-1:0]          req_expected_power,
   input  logic [MsWidth-1:0]             req_ms_count,
   input  logic                           req_remote_closed,
   input  logic [PowerWidth-1:0]          power_limit,
   input  logic [LimitWidth-1:0]          startup_frame_limit,
   input  logic [PowerWidth-1:0]          startup_budget,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_frame_wheel,
   output logic signed [AngleWidth-1:0]   rsp_frame_angle,
   output logic signed [AngleWidth-1:0]   rsp_frame_speed,
   output logic [PowerWidth-1:0]          rsp_frame_budget
);

   localparam int WheelBits  = $clog2(WHEELS);
   localparam int SlotBits   = $clog2(SLOTS);
   localparam int SumWidth   = PowerWidth + WheelBits;
   localparam int ProdWidth  = 2 * PowerWidth;
   localparam int DivSteps   = ProdWidth;
   localparam int StepBits   = $clog2(DivSteps + 1);
   localparam int DigitSteps = MsWidth / 4;
   localparam int MsBits     = $clog2(DigitSteps + 1);
   localparam logic [CountWidth-1:0] CountMax = '1;

   // Residue of (remainder * 16 + digit) by SLOTS, built as a constant table.
   function automatic logic [SlotBits-1:0] slot_residue(input logic [7:0] value);
      logic [SlotBits-1:0] r;
      r = '0;
      for (int i = 0; i < 256; i++) begin
         if (value == 8'(i)) begin
            r = SlotBits'(i % SLOTS);
         end
      end
      return r;
   endfunction

   logic [AngleWidth-1:0] angle_ff [WHEELS];
   logic [AngleWidth-1:0] speed_ff [WHEELS];
   logic [PowerWidth-1:0] expected_ff [WHEELS];
   logic [PowerWidth-1:0] budget_ff [WHEELS];
   logic [WHEELS-1:0]     ready_ff, ready_in;
   logic [CountWidth-1:0] count_ff, count_in;

   // The slot is found four bits of ms_count a cycle, most significant first.
   logic [MsWidth-1:0]    ms_ff;
   logic [SlotBits-1:0]   rem_ff, rem_in;
   logic [MsBits-1:0]     ms_idx_ff;
   logic                  closed_ff;

   logic [SumWidth-1:0]   sum_ff;
   logic [WheelBits-1:0]  widx_ff;
   logic [ProdWidth-1:0]  quo_ff;
   logic [SumWidth:0]     prem_ff;
   logic [StepBits-1:0]   step_ff;
   logic                  scale_ff;

   logic [SumWidth:0]     prem_shift;
   logic [ProdWidth-1:0]  product;
   logic [WheelBits-1:0]  slot_w;
   logic                  slot_ok;

   logic [AngleWidth-1:0] angle_out_ff, speed_out_ff;
   logic [PowerWidth-1:0] budget_out_ff;
   logic [1:0]            wheel_out_ff;
   logic                  valid_ff;

   assign rem_in     = slot_residue({4'(rem_ff), ms_ff[MsWidth-1 -: 4]});
   assign prem_shift = {prem_ff[SumWidth-1:0], quo_ff[ProdWidth-1]};
   assign product    = ProdWidth'(expected_ff[widx_ff]) * ProdWidth'(power_limit);
   assign slot_ok    = 32'(rem_ff) < WHEELS;
   assign slot_w     = WheelBits'(rem_ff);

   assign status.slot_done  = ms_idx_ff == MsBits'(DigitSteps);
   assign status.sum_done   = widx_ff == WheelBits'(WHEELS - 1);
   assign status.div_done   = step_ff == StepBits'(DivSteps);
   assign status.last_wheel = widx_ff == WheelBits'(WHEELS - 1);

   always_comb begin
      ready_in = ready_ff;
      count_in = count_ff;
      if (ctrl.mark_ready && (32'(req_wheel) < WHEELS)) begin
         ready_in[WheelBits'(req_wheel)] = 1'b1;
      end
      if (ctrl.frame_emit && slot_ok && ready_ff[slot_w]) begin
         ready_in[slot_w] = 1'b0;
         if (!closed_ff && count_ff != CountMax) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
         for (int i = 0; i < WHEELS; i++) begin
            angle_ff[i]    <= '0;
            speed_ff[i]    <= '0;
            expected_ff[i] <= '0;
            budget_ff[i]   <= '0;
         end
      end else begin
         ready_ff <= ready_in;
         count_ff <= count_in;
         valid_ff <= ctrl.frame_emit && slot_ok && ready_ff[slot_w];
         if (ctrl.load && (32'(req_wheel) < WHEELS)) begin
            angle_ff[WheelBits'(req_wheel)]    <= req_target_angle;
            speed_ff[WheelBits'(req_wheel)]    <= req_target_speed;
            expected_ff[WheelBits'(req_wheel)] <= req_expected_power;
         end
         if (ctrl.budget_store) begin
            budget_ff[widx_ff] <= scale_ff ? quo_ff[PowerWidth-1:0] : expected_ff[widx_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture_tick) begin
         ms_ff     <= req_ms_count;
         closed_ff <= req_remote_closed;
         rem_ff    <= '0;
         ms_idx_ff <= '0;
      end else if (ctrl.slot_step) begin
         ms_ff     <= {ms_ff[MsWidth-5:0], 4'b0000};
         rem_ff    <= rem_in;
         ms_idx_ff <= ms_idx_ff + 1'b1;
      end
      if (ctrl.sum_clear) begin
         sum_ff  <= SumWidth'(expected_ff[0]);
         widx_ff <= '0;
      end else if (ctrl.sum_add) begin
         sum_ff  <= sum_ff + SumWidth'(expected_ff[widx_ff + 1'b1]);
         widx_ff <= widx_ff + 1'b1;
      end else if (ctrl.index_clear) begin
         widx_ff <= '0;
      end else if (ctrl.budget_store) begin
         widx_ff <= widx_ff + 1'b1;
      end
      if (ctrl.div_load) begin
         quo_ff   <= product;
         prem_ff  <= '0;
         step_ff  <= '0;
         scale_ff <= (sum_ff != '0) && (sum_ff >= SumWidth'(power_limit));
      end else if (ctrl.div_step) begin
         if (prem_shift >= (SumWidth+1)'(sum_ff)) begin
            prem_ff <= prem_shift - (SumWidth+1)'(sum_ff);
            quo_ff  <= {quo_ff[ProdWidth-2:0], 1'b1};
         end else begin
            prem_ff <= prem_shift;
            quo_ff  <= {quo_ff[ProdWidth-2:0], 1'b0};
         end
         step_ff <= step_ff + 1'b1;
      end
      if (ctrl.frame_emit) begin
         wheel_out_ff <= 2'(slot_w);
         angle_out_ff <= angle_ff[slot_w];
         speed_out_ff <= closed_ff ? '0 : speed_ff[slot_w];
         if (!closed_ff && (count_in <= CountWidth'(startup_frame_limit))) begin
            budget_out_ff <= startup_budget;
         end else begin
            budget_out_ff <= budget_ff[slot_w];
         end
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_frame_wheel  = wheel_out_ff;
   assign rsp_frame_angle  = angle_out_ff;
   assign rsp_frame_speed  = speed_out_ff;
   assign rsp_frame_budget = budget_out_ff;

endmodule

// File: design/wcps_control.sv
module wcps_control
   import wcps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_start,
   input  logic [1:0] req_func,
   input  status_type status,
   output ctrl_type   ctrl,
   output logic       req_busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      req_busy = state_ff != ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_start) begin
               case (req_func)
                  FUNC_LOAD:    ctrl.load = 1'b1;
                  FUNC_READY:   ctrl.mark_ready = 1'b1;
                  FUNC_COMPUTE: begin
                     ctrl.sum_clear = 1'b1;
                     state_in = ST_SUM;
                  end
                  default: begin
                     ctrl.capture_tick = 1'b1;
                     state_in = ST_SLOT;
                  end
               endcase
            end
         end
         ST_SLOT: begin
            if (status.slot_done) begin
               ctrl.frame_emit = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ctrl.slot_step = 1'b1;
            end
         end
         ST_SUM: begin
            if (status.sum_done) begin
               ctrl.index_clear = 1'b1;
               state_in = ST_DIV_START;
            end else begin
               ctrl.sum_add = 1'b1;
            end
         end
         ST_DIV_START: begin
            // The wheel index was cleared when the sum completed, or stepped by the last store.
            ctrl.div_load = 1'b1;
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (status.div_done) begin
               state_in = ST_DIV_STORE;
            end else begin
               ctrl.div_step = 1'b1;
            end
         end
         ST_DIV_STORE: begin
            ctrl.budget_store = 1'b1;
            state_in = status.last_wheel ? ST_IDLE : ST_DIV_START;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: design/wheel_command_power_scheduler.sv
// Load and ready items complete in ST_IDLE without raising busy.
// A tick item reduces ms_count four bits a cycle to find the slot; its frame,
// if any, is strobed by rsp_valid in the cycle in which busy falls.
// A recompute item sums the expected powers, then runs the 48-step divider once per wheel.
// The receiver cannot stall, so a frame never holds off the next item.
// Reset clears all stored targets, budgets, ready bits and the frame counter.
module wheel_command_power_scheduler
   import wcps_pkg::*;
#(
   parameter int WHEELS = WheelsDefault,
   parameter int SLOTS  = SlotsDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_func,
   input  logic [1:0]                   req_wheel,
   input  logic signed [AngleWidth-1:0] req_target_angle,
   input  logic signed [AngleWidth-1:0] req_target_speed,
   input  logic [PowerWidth-1:0]        req_expected_power,
   input  logic [MsWidth-1:0]           req_ms_count,
   input  logic                         req_remote_closed,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_frame_wheel,
   output logic signed [AngleWidth-1:0] rsp_frame_angle,
   output logic signed [AngleWidth-1:0] rsp_frame_speed,
   output logic [PowerWidth-1:0]        rsp_frame_budget,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [3:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   logic [PowerWidth-1:0] limit_ff, sbudget_ff;
   logic [LimitWidth-1:0] flimit_ff;
   ctrl_type   ctrl;
   status_type status;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= PowerLimitReset;
         flimit_ff  <= FrameLimitReset;
         sbudget_ff <= StartupBudgetReset;
      end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
         case (paddr[3:2])
            RegPowerLimit:    limit_ff   <= pwdata[PowerWidth-1:0];
            RegFrameLimit:    flimit_ff  <= pwdata[LimitWidth-1:0];
            RegStartupBudget: sbudget_ff <= pwdata[PowerWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         RegPowerLimit:    prdata = 32'(limit_ff);
         RegFrameLimit:    prdata = 32'(flimit_ff);
         RegStartupBudget: prdata = 32'(sbudget_ff);
         default:          prdata = '0;
      endcase
   end

   wcps_control u_control (
      .clock    (clock),
      .reset    (reset),
      .req_start(start),
      .req_func (req_func),
      .status   (status),
      .ctrl     (ctrl),
      .req_busy (busy)
   );

   wcps_datapath #(.WHEELS(WHEELS), .SLOTS(SLOTS)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .status             (status),
      .req_wheel          (req_wheel),
      .req_target_angle   (req_target_angle),
      .req_target_speed   (req_target_speed),
      .req_expected_power (req_expected_power),
      .req_ms_count       (req_ms_count),
      .req_remote_closed  (req_remote_closed),
      .power_limit        (limit_ff),
      .startup_frame_limit(flimit_ff),
      .startup_budget     (sbudget_ff),
      .rsp_valid          (rsp_valid),
      .rsp_frame_wheel    (rsp_frame_wheel),
      .rsp_frame_angle    (rsp_frame_angle),
      .rsp_frame_speed    (rsp_frame_speed),
      .rsp_frame_budget   (rsp_frame_budget)
   );

endmodule
